@@ hw/rtl/ppi_pkg.sv @@
// types, constants and the arctangent table shared by the pose integrator
package ppi_pkg;

  // one input item
  typedef struct packed {
    logic               op;
    logic signed [15:0] cmd_vx;
    logic signed [15:0] cmd_vy;
    logic signed [15:0] cmd_wz;
    logic        [15:0] tick_dt;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_z;
    logic        [15:0] heading;
    logic signed [15:0] out_vx;
    logic signed [15:0] out_vy;
    logic signed [15:0] out_wz;
    logic               cmd_active;
  } out_item_t;

  typedef logic [2:0] cfg_index_t;

  // register indexes
  localparam cfg_index_t REG_MAX_LIN   = 3'd0;
  localparam cfg_index_t REG_MAX_ANG   = 3'd1;
  localparam cfg_index_t REG_TIMEOUT   = 3'd2;
  localparam cfg_index_t REG_START_X   = 3'd3;
  localparam cfg_index_t REG_START_Y   = 3'd4;
  localparam cfg_index_t REG_START_Z   = 3'd5;
  localparam cfg_index_t REG_START_HDG = 3'd6;

  // item kinds
  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // time step limit, 0.1 s in 2^-16 s
  localparam logic [15:0] DT_MAX  = 16'd6554;
  localparam int unsigned DT_BITS = 13;

  localparam logic [20:0] AGE_MAX = 21'h1FFFFF;

  // cordic gain 0.6073 in Q32
  localparam logic [31:0] CORDIC_GAIN_Q32 = 32'd2608131496;

  // 65536 / (2 pi) in Q16, scaled result shifted down by YAW_SHIFT
  localparam int unsigned RAD_BITS       = 30;
  localparam logic [29:0] RAD_TO_BAM_Q16 = 30'd683565276;
  localparam int unsigned YAW_SHIFT      = 40;

  // arctangent of 2^-i as a fraction of a turn, 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    case (idx)
      5'd0:    return 32'h20000000;
      5'd1:    return 32'h12E4051D;
      5'd2:    return 32'h09FB385B;
      5'd3:    return 32'h051111D4;
      5'd4:    return 32'h028B0D43;
      5'd5:    return 32'h0145D7E1;
      5'd6:    return 32'h00A2F61E;
      5'd7:    return 32'h00517C55;
      5'd8:    return 32'h0028BE53;
      5'd9:    return 32'h00145F2E;
      5'd10:   return 32'h000A2F98;
      5'd11:   return 32'h000517CC;
      5'd12:   return 32'h00028BE6;
      5'd13:   return 32'h000145F3;
      5'd14:   return 32'h0000A2F9;
      5'd15:   return 32'h0000517C;
      5'd16:   return 32'h000028BE;
      5'd17:   return 32'h0000145F;
      5'd18:   return 32'h00000A2F;
      5'd19:   return 32'h00000517;
      5'd20:   return 32'h0000028B;
      5'd21:   return 32'h00000145;
      5'd22:   return 32'h000000A2;
      5'd23:   return 32'h00000051;
      default: return 32'h00000000;
    endcase
  endfunction

endpackage

@@ hw/rtl/planar_pose_integrator_top.sv @@
// dead-reckoning pose integrator with cordic rotation and bit-serial multiplies
// a command item is taken in idle and gives no result; a tick whose command is stale
//   goes straight to the output state; an active tick first runs the cordic loop, the
//   velocity multiply (one speed bit at a time), the time multiply and the pose update
// one item at a time: the input is ready only in idle, and the output state waits
//   for the output register to free up
// reset: async active low; pose, held command, age and registers take their reset values
module planar_pose_integrator_top #(
  parameter int unsigned TRIG_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ppi_pkg::in_item_t     in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ppi_pkg::out_item_t    out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  ppi_pkg::cfg_index_t   cfg_index_i,
  input  logic [31:0]           cfg_data_i
);
  import ppi_pkg::*;

  // cordic x and y carry a sign and one guard bit over the Q(TRIG_BITS) range
  localparam int unsigned CW     = TRIG_BITS + 2;
  // world speed vx*c - vy*s
  localparam int unsigned WX_W   = TRIG_BITS + 19;
  // world speed times dt
  localparam int unsigned WV_W   = WX_W + 14;
  localparam int unsigned SHX    = TRIG_BITS + 8;
  localparam int unsigned SX_W   = WV_W - SHX;
  // turn rate times dt, then times the radian to binary angle factor
  localparam int unsigned WZD_W  = 30;
  localparam int unsigned YAW_W  = WZD_W + RAD_BITS + 1;
  localparam int unsigned CNT_W  = 5;

  localparam logic [CNT_W-1:0] ROT_LAST  = CNT_W'(TRIG_BITS - 1);
  localparam logic [CNT_W-1:0] VMUL_LAST = CNT_W'(15);
  localparam logic [CNT_W-1:0] DMUL_LAST = CNT_W'(RAD_BITS - 1);

  localparam logic signed [CW-1:0] CORDIC_X0 = CW'(CORDIC_GAIN_Q32 >> (32 - TRIG_BITS));
  localparam logic [WV_W-1:0]  HALF_X   = WV_W'(1) << (SHX - 1);
  localparam logic [YAW_W-1:0] HALF_YAW = YAW_W'(1) << (YAW_SHIFT - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROT  = 3'd1;
  localparam logic [2:0] ST_VMUL = 3'd2;
  localparam logic [2:0] ST_DMUL = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  // symmetric clamp of a signed speed to +/- lim
  function automatic logic [15:0] clamp_sym(input logic [15:0] v, input logic [14:0] lim);
    logic signed [16:0] hi;
    logic signed [16:0] lo;
    logic signed [16:0] val;
    hi  = $signed({2'b00, lim});
    lo  = -hi;
    val = $signed({v[15], v});
    if (val > hi) begin
      return hi[15:0];
    end else if (val < lo) begin
      return lo[15:0];
    end
    return v;
  endfunction

  // control and architectural state
  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [14:0]      max_lin_q, max_lin_d;
  logic [14:0]      max_ang_q, max_ang_d;
  logic [19:0]      timeout_q, timeout_d;
  logic [31:0]      start_z_q, start_z_d;
  logic [31:0]      pos_x_q, pos_x_d;
  logic [31:0]      pos_y_q, pos_y_d;
  logic [15:0]      yaw_q, yaw_d;
  logic [15:0]      held_vx_q, held_vx_d;
  logic [15:0]      held_vy_q, held_vy_d;
  logic [15:0]      held_wz_q, held_wz_d;
  logic             cmd_seen_q, cmd_seen_d;
  logic [20:0]      cmd_age_q, cmd_age_d;
  logic             active_q, active_d;

  // datapath registers
  logic [12:0]            dt_q, dt_d;
  logic signed [CW-1:0]   x_q, x_d;
  logic signed [CW-1:0]   y_q, y_d;
  logic [31:0]            z_q, z_d;
  logic [1:0]             quad_q, quad_d;
  logic [WX_W-1:0]        c_sh_q, c_sh_d;
  logic [WX_W-1:0]        s_sh_q, s_sh_d;
  logic [15:0]            vx_sh_q, vx_sh_d;
  logic [15:0]            vy_sh_q, vy_sh_d;
  logic [WZD_W-1:0]       wz_sh_q, wz_sh_d;
  logic [12:0]            dt_sh_q, dt_sh_d;
  logic [WX_W-1:0]        accx_q, accx_d;
  logic [WX_W-1:0]        accy_q, accy_d;
  logic [WZD_W-1:0]       wzdt_q, wzdt_d;
  logic [WV_W-1:0]        wx_sh_q, wx_sh_d;
  logic [WV_W-1:0]        wy_sh_q, wy_sh_d;
  logic [WV_W-1:0]        accpx_q, accpx_d;
  logic [WV_W-1:0]        accpy_q, accpy_d;
  logic [YAW_W-1:0]       wzk_sh_q, wzk_sh_d;
  logic [RAD_BITS-1:0]    k_sh_q, k_sh_d;
  logic [YAW_W-1:0]       accyaw_q, accyaw_d;
  out_item_t              out_q, out_d;

  // handshakes
  logic in_fire;
  logic cfg_fire;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // tick front end: saturate dt, age the command, decide if it still drives motion
  logic [12:0] dt_sat;
  logic [21:0] age_sum;
  logic [20:0] age_new;
  logic        tick_active;
  assign dt_sat      = (in_data_i.tick_dt > DT_MAX) ? DT_MAX[12:0] : in_data_i.tick_dt[12:0];
  assign age_sum     = {1'b0, cmd_age_q} + {9'b0, dt_sat};
  assign age_new     = age_sum[21] ? AGE_MAX : age_sum[20:0];
  assign tick_active = cmd_seen_q &&
                       ((timeout_q == '0) || (age_new <= {1'b0, timeout_q}));

  // nearest quadrant of the yaw and the residual angle, 2^16 per turn
  logic [15:0] yaw_bias;
  logic [1:0]  quad_new;
  logic [15:0] rem16;
  assign yaw_bias = yaw_q + 16'h2000;
  assign quad_new = yaw_bias[15:14];
  assign rem16    = yaw_q - {quad_new, 14'b0};

  // one cordic micro-rotation per cycle, shift set by the iteration count
  logic signed [CW-1:0] dx_rot, dy_rot, x_n, y_n;
  logic [31:0]          z_n, atan_i;
  assign dx_rot = y_q >>> cnt_q;
  assign dy_rot = x_q >>> cnt_q;
  assign atan_i = atan_turn(cnt_q);
  assign x_n    = z_q[31] ? (x_q + dx_rot) : (x_q - dx_rot);
  assign y_n    = z_q[31] ? (y_q - dy_rot) : (y_q + dy_rot);
  assign z_n    = z_q[31] ? (z_q + atan_i) : (z_q - atan_i);

  // fold the quadrant back in to get cos and sin
  logic signed [CW-1:0] c_fin, s_fin;
  always_comb begin
    case (quad_q)
      2'd0: begin
        c_fin = x_n;
        s_fin = y_n;
      end
      2'd1: begin
        c_fin = -y_n;
        s_fin = x_n;
      end
      2'd2: begin
        c_fin = -x_n;
        s_fin = -y_n;
      end
      default: begin
        c_fin = y_n;
        s_fin = -x_n;
      end
    endcase
  end

  // velocity rotation, one bit of vx and vy per cycle; the sign bit weighs negative
  logic [WX_W-1:0]  ppx, ppy, accx_n, accy_n;
  logic [WZD_W-1:0] wzdt_n;
  assign ppx    = (vx_sh_q[0] ? c_sh_q : '0) - (vy_sh_q[0] ? s_sh_q : '0);
  assign ppy    = (vx_sh_q[0] ? s_sh_q : '0) + (vy_sh_q[0] ? c_sh_q : '0);
  assign accx_n = (cnt_q == VMUL_LAST) ? (accx_q - ppx) : (accx_q + ppx);
  assign accy_n = (cnt_q == VMUL_LAST) ? (accy_q - ppy) : (accy_q + ppy);
  assign wzdt_n = wzdt_q + (dt_sh_q[0] ? wz_sh_q : '0);

  // rounding to Q16.16 steps and binary angle step
  logic [WV_W-1:0]  rnd_x, rnd_y;
  logic [YAW_W-1:0] rnd_yaw;
  logic [31:0]      step_x, step_y;
  assign rnd_x   = accpx_q + HALF_X;
  assign rnd_y   = accpy_q + HALF_X;
  assign rnd_yaw = accyaw_q + HALF_YAW;
  assign step_x  = {{(32 - SX_W){rnd_x[WV_W-1]}}, rnd_x[WV_W-1:SHX]};
  assign step_y  = {{(32 - SX_W){rnd_y[WV_W-1]}}, rnd_y[WV_W-1:SHX]};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    max_lin_d   = max_lin_q;
    max_ang_d   = max_ang_q;
    timeout_d   = timeout_q;
    start_z_d   = start_z_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    yaw_d       = yaw_q;
    held_vx_d   = held_vx_q;
    held_vy_d   = held_vy_q;
    held_wz_d   = held_wz_q;
    cmd_seen_d  = cmd_seen_q;
    cmd_age_d   = cmd_age_q;
    active_d    = active_q;
    dt_d        = dt_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    quad_d      = quad_q;
    c_sh_d      = c_sh_q;
    s_sh_d      = s_sh_q;
    vx_sh_d     = vx_sh_q;
    vy_sh_d     = vy_sh_q;
    wz_sh_d     = wz_sh_q;
    dt_sh_d     = dt_sh_q;
    accx_d      = accx_q;
    accy_d      = accy_q;
    wzdt_d      = wzdt_q;
    wx_sh_d     = wx_sh_q;
    wy_sh_d     = wy_sh_q;
    accpx_d     = accpx_q;
    accpy_d     = accpy_q;
    wzk_sh_d    = wzk_sh_q;
    k_sh_d      = k_sh_q;
    accyaw_d    = accyaw_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.op == OP_CMD) begin
            // store the clamped command and restart its age
            held_vx_d  = clamp_sym(in_data_i.cmd_vx, max_lin_q);
            held_vy_d  = clamp_sym(in_data_i.cmd_vy, max_lin_q);
            held_wz_d  = clamp_sym(in_data_i.cmd_wz, max_ang_q);
            cmd_age_d  = '0;
            cmd_seen_d = 1'b1;
          end else begin
            cmd_age_d = age_new;
            active_d  = tick_active;
            dt_d      = dt_sat;
            // load the rotation and the first multiply pass
            x_d       = CORDIC_X0;
            y_d       = '0;
            z_d       = {rem16, 16'h0000};
            quad_d    = quad_new;
            vx_sh_d   = held_vx_q;
            vy_sh_d   = held_vy_q;
            wz_sh_d   = {{(WZD_W - 16){held_wz_q[15]}}, held_wz_q};
            dt_sh_d   = dt_sat;
            accx_d    = '0;
            accy_d    = '0;
            wzdt_d    = '0;
            cnt_d     = '0;
            state_d   = tick_active ? ST_ROT : ST_OUT;
          end
        end
      end
      ST_ROT: begin
        x_d   = x_n;
        y_d   = y_n;
        z_d   = z_n;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ROT_LAST) begin
          c_sh_d  = {{(WX_W - CW){c_fin[CW-1]}}, c_fin};
          s_sh_d  = {{(WX_W - CW){s_fin[CW-1]}}, s_fin};
          cnt_d   = '0;
          state_d = ST_VMUL;
        end
      end
      ST_VMUL: begin
        accx_d  = accx_n;
        accy_d  = accy_n;
        wzdt_d  = wzdt_n;
        c_sh_d  = {c_sh_q[WX_W-2:0], 1'b0};
        s_sh_d  = {s_sh_q[WX_W-2:0], 1'b0};
        vx_sh_d = {1'b0, vx_sh_q[15:1]};
        vy_sh_d = {1'b0, vy_sh_q[15:1]};
        wz_sh_d = {wz_sh_q[WZD_W-2:0], 1'b0};
        dt_sh_d = {1'b0, dt_sh_q[12:1]};
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == VMUL_LAST) begin
          // world speeds and turn rate times dt go to the second pass
          wx_sh_d  = {{(WV_W - WX_W){accx_n[WX_W-1]}}, accx_n};
          wy_sh_d  = {{(WV_W - WX_W){accy_n[WX_W-1]}}, accy_n};
          wzk_sh_d = {{(YAW_W - WZD_W){wzdt_n[WZD_W-1]}}, wzdt_n};
          k_sh_d   = RAD_TO_BAM_Q16;
          dt_sh_d  = dt_q;
          accpx_d  = '0;
          accpy_d  = '0;
          accyaw_d = '0;
          cnt_d    = '0;
          state_d  = ST_DMUL;
        end
      end
      ST_DMUL: begin
        accpx_d  = accpx_q + (dt_sh_q[0] ? wx_sh_q : '0);
        accpy_d  = accpy_q + (dt_sh_q[0] ? wy_sh_q : '0);
        accyaw_d = accyaw_q + (k_sh_q[0] ? wzk_sh_q : '0);
        wx_sh_d  = {wx_sh_q[WV_W-2:0], 1'b0};
        wy_sh_d  = {wy_sh_q[WV_W-2:0], 1'b0};
        wzk_sh_d = {wzk_sh_q[YAW_W-2:0], 1'b0};
        dt_sh_d  = {1'b0, dt_sh_q[12:1]};
        k_sh_d   = {1'b0, k_sh_q[RAD_BITS-1:1]};
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == DMUL_LAST) begin
          cnt_d   = '0;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        pos_x_d = pos_x_q + step_x;
        pos_y_d = pos_y_q + step_y;
        yaw_d   = yaw_q + rnd_yaw[YAW_SHIFT+15:YAW_SHIFT];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          out_d.pose_x     = pos_x_q;
          out_d.pose_y     = pos_y_q;
          out_d.pose_z     = start_z_q;
          out_d.heading    = yaw_q;
          out_d.out_vx     = active_q ? held_vx_q : '0;
          out_d.out_vy     = active_q ? held_vy_q : '0;
          out_d.out_wz     = active_q ? held_wz_q : '0;
          out_d.cmd_active = active_q;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // register writes; start values also load the pose
    if (cfg_fire) begin
      unique case (cfg_index_i)
        REG_MAX_LIN:   max_lin_d = cfg_data_i[14:0];
        REG_MAX_ANG:   max_ang_d = cfg_data_i[14:0];
        REG_TIMEOUT:   timeout_d = cfg_data_i[19:0];
        REG_START_X:   pos_x_d   = cfg_data_i;
        REG_START_Y:   pos_y_d   = cfg_data_i;
        REG_START_Z:   start_z_d = cfg_data_i;
        REG_START_HDG: yaw_d     = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      max_lin_q   <= 15'd256;
      max_ang_q   <= 15'd384;
      timeout_q   <= 20'd32768;
      start_z_q   <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      yaw_q       <= '0;
      held_vx_q   <= '0;
      held_vy_q   <= '0;
      held_wz_q   <= '0;
      cmd_seen_q  <= 1'b0;
      cmd_age_q   <= '0;
      active_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      max_lin_q   <= max_lin_d;
      max_ang_q   <= max_ang_d;
      timeout_q   <= timeout_d;
      start_z_q   <= start_z_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      yaw_q       <= yaw_d;
      held_vx_q   <= held_vx_d;
      held_vy_q   <= held_vy_d;
      held_wz_q   <= held_wz_d;
      cmd_seen_q  <= cmd_seen_d;
      cmd_age_q   <= cmd_age_d;
      active_q    <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q     <= dt_d;
    x_q      <= x_d;
    y_q      <= y_d;
    z_q      <= z_d;
    quad_q   <= quad_d;
    c_sh_q   <= c_sh_d;
    s_sh_q   <= s_sh_d;
    vx_sh_q  <= vx_sh_d;
    vy_sh_q  <= vy_sh_d;
    wz_sh_q  <= wz_sh_d;
    dt_sh_q  <= dt_sh_d;
    accx_q   <= accx_d;
    accy_q   <= accy_d;
    wzdt_q   <= wzdt_d;
    wx_sh_q  <= wx_sh_d;
    wy_sh_q  <= wy_sh_d;
    accpx_q  <= accpx_d;
    accpy_q  <= accpy_d;
    wzk_sh_q <= wzk_sh_d;
    k_sh_q   <= k_sh_d;
    accyaw_q <= accyaw_d;
    out_q    <= out_d;
  end

  // a command item never starts the sequencer
  a_cmd_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.op == OP_CMD)) |=> (state_q == ST_IDLE))
    else $error("command item left the idle state");

  // a stale tick goes straight to the result
  a_stale_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.op == OP_TICK) && !tick_active) |=> (state_q == ST_OUT))
    else $error("stale tick entered the datapath");

  // the pose update follows a complete time multiply
  a_full_dmul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> (($past(state_q) == ST_DMUL) && ($past(cnt_q) == DMUL_LAST)))
    else $error("pose update without a full multiply pass");

  // dt is fully shifted out before the time multiply ends
  a_dt_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DMUL) && (cnt_q >= CNT_W'(DT_BITS))) |-> (dt_sh_q == '0))
    else $error("dt bits left after the time multiply");

  // an active result needs a command seen before
  a_active_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.cmd_active) |-> cmd_seen_q)
    else $error("active result without any command");

endmodule

@@ tb/planar_pose_integrator_top_test.sv @@
// self-checking testbench for the planar pose integrator: random and directed items, scoreboard
`timescale 1ns / 100ps

module planar_pose_integrator_top_test;
  import ppi_pkg::*;

  // cordic iterations, also handed to the block
  localparam int TRIG_STEPS = 16;
  // tick length cap, 0.1 s in 2^-16 s
  localparam int DT_CAP = 6554;
  // command age saturates at the top of its 21 bits
  localparam int AGE_CAP = 2097151;
  // cordic gain in Q32
  localparam longint GAIN_Q32 = 64'd2608131496;
  // radians to binary angle, 65536 / (2 pi) in Q16
  localparam longint YAW_SCALE = 64'd683565276;
  localparam int YAW_SHIFT = 40;
  // an index past the register list, writes to it are dropped
  localparam cfg_index_t REG_UNUSED = 3'd7;
  // cycles after the last result before the block is surely idle
  localparam int SETTLE_CYCLES = 80;
  // length of the long receiver hold-off
  localparam int HOLD_OFF_CYCLES = 300;
  // ticks without a fresh command, enough to saturate the command age
  localparam int COAST_TICKS = 330;

  // predicts the pose for every tick and checks results in order
  class pose_scoreboard;
    logic [14:0] lin_limit;
    logic [14:0] ang_limit;
    logic [19:0] timeout;
    logic [31:0] height;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] yaw;
    int          held_vx;
    int          held_vy;
    int          held_wz;
    bit          cmd_seen;
    int          cmd_age;
    bit   [31:0] arc_step [16];
    out_item_t   pending_poses [$];
    int          mismatch_count;

    function new();
      lin_limit = 15'd256;
      ang_limit = 15'd384;
      timeout = 20'd32768;
      height = '0;
      pos_x = '0;
      pos_y = '0;
      yaw = '0;
      held_vx = 0;
      held_vy = 0;
      held_wz = 0;
      cmd_seen = 0;
      cmd_age = 0;
      mismatch_count = 0;
      // atan(2^-i) in turns, 2^32 per turn
      arc_step = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
                   32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                   32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
                   32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C};
    endfunction

    function int pending_count();
      return pending_poses.size();
    endfunction

    function void load_reg(cfg_index_t idx, logic [31:0] data);
      case (idx)
        REG_MAX_LIN:   lin_limit = data[14:0];
        REG_MAX_ANG:   ang_limit = data[14:0];
        REG_TIMEOUT:   timeout = data[19:0];
        REG_START_X:   pos_x = data;
        REG_START_Y:   pos_y = data;
        REG_START_Z:   height = data;
        REG_START_HDG: yaw = data[15:0];
        default: ;
      endcase
    endfunction

    function int clamp_speed(logic [15:0] raw, logic [14:0] lim);
      int v;
      int m;
      v = int'($signed(raw));
      m = int'(lim);
      if (v > m) return m;
      if (v < -m) return -m;
      return v;
    endfunction

    function longint round_half_up(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    // cos and sin of a binary angle: nearest quadrant, then cordic on the rest
    function void unit_vector(input logic [15:0] angle, output longint c, output longint s);
      logic [31:0] a;
      logic [31:0] shifted;
      logic [31:0] rem;
      logic [1:0]  q;
      longint      x;
      longint      y;
      longint      z;
      longint      dx;
      longint      dy;
      a = {angle, 16'h0000};
      shifted = a + 32'h2000_0000;
      q = shifted[31:30];
      rem = a - {q, 30'b0};
      z = longint'($signed(rem));
      x = GAIN_Q32 >>> (32 - TRIG_STEPS);
      y = 0;
      for (int i = 0; i < TRIG_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - longint'(arc_step[i]);
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + longint'(arc_step[i]);
        end
      end
      case (q)
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function void note_item(in_item_t item);
      int        dt;
      bit        active;
      longint    c;
      longint    s;
      longint    wx;
      longint    wy;
      longint    dyaw;
      out_item_t want;
      if (item.op == OP_CMD) begin
        held_vx = clamp_speed(item.cmd_vx, lin_limit);
        held_vy = clamp_speed(item.cmd_vy, lin_limit);
        held_wz = clamp_speed(item.cmd_wz, ang_limit);
        cmd_age = 0;
        cmd_seen = 1;
        return;
      end
      dt = (int'(item.tick_dt) > DT_CAP) ? DT_CAP : int'(item.tick_dt);
      cmd_age = cmd_age + dt;
      if (cmd_age > AGE_CAP) cmd_age = AGE_CAP;
      active = cmd_seen && (timeout == 0 || cmd_age <= int'(timeout));
      if (active) begin
        unit_vector(yaw, c, s);
        wx = longint'(held_vx) * c - longint'(held_vy) * s;
        wy = longint'(held_vx) * s + longint'(held_vy) * c;
        pos_x = pos_x + 32'(round_half_up(wx * longint'(dt), 8 + TRIG_STEPS));
        pos_y = pos_y + 32'(round_half_up(wy * longint'(dt), 8 + TRIG_STEPS));
        dyaw = round_half_up(longint'(held_wz) * longint'(dt) * YAW_SCALE, YAW_SHIFT);
        yaw = yaw + dyaw[15:0];
      end
      want = '0;
      want.pose_x = pos_x;
      want.pose_y = pos_y;
      want.pose_z = height;
      want.heading = yaw;
      if (active) begin
        want.out_vx = 16'(held_vx);
        want.out_vy = 16'(held_vy);
        want.out_wz = 16'(held_wz);
        want.cmd_active = 1'b1;
      end
      pending_poses.push_back(want);
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      $display("%0t mismatch on %s: got %h, want %h", $time, field, got, want);
    endtask

    task check_pose(out_item_t got);
      out_item_t want;
      if (pending_poses.size() == 0) begin
        report_mismatch("result with nothing pending", got.pose_x, 32'h0);
        return;
      end
      want = pending_poses.pop_front();
      if (got.pose_x !== want.pose_x) report_mismatch("pose_x", got.pose_x, want.pose_x);
      if (got.pose_y !== want.pose_y) report_mismatch("pose_y", got.pose_y, want.pose_y);
      if (got.pose_z !== want.pose_z) report_mismatch("pose_z", got.pose_z, want.pose_z);
      if (got.heading !== want.heading)
        report_mismatch("heading", 32'(got.heading), 32'(want.heading));
      if (got.out_vx !== want.out_vx)
        report_mismatch("out_vx", 32'(got.out_vx), 32'(want.out_vx));
      if (got.out_vy !== want.out_vy)
        report_mismatch("out_vy", 32'(got.out_vy), 32'(want.out_vy));
      if (got.out_wz !== want.out_wz)
        report_mismatch("out_wz", 32'(got.out_wz), 32'(want.out_wz));
      if (got.cmd_active !== want.cmd_active)
        report_mismatch("cmd_active", 32'(got.cmd_active), 32'(want.cmd_active));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_item_t   in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_item_t  out_data_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  cfg_index_t cfg_index_i;
  logic [31:0] cfg_data_i;

  // idle odds in percent per cycle, set per phase by the stimulus
  int src_idle_pct;
  int sink_idle_pct;
  // flipped by the stimulus to start one long receiver hold-off
  bit hold_off_toggle;

  pose_scoreboard sb = new();

  planar_pose_integrator_top #(
    .TRIG_BITS(TRIG_STEPS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // every accepted result goes to the scoreboard, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_pose(out_data_o);
  end

  // receiver: random ready at the falling edge, or a long hold-off when asked
  initial begin : result_sink
    int hold_left;
    bit seen_toggle;
    hold_left = 0;
    seen_toggle = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_toggle != seen_toggle) begin
        seen_toggle = hold_off_toggle;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // hard stop well past the slowest correct run
  initial begin : watchdog
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the item is taken,
  // with valid still high so the next item follows without a gap
  task automatic offer_item(input in_item_t item);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = item;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(item);
    @(negedge clk_i);
  endtask

  // ignored fields of each kind of item still get random content
  task automatic send_cmd(input logic [15:0] vx, input logic [15:0] vy, input logic [15:0] wz);
    in_item_t item;
    item.op = OP_CMD;
    item.cmd_vx = vx;
    item.cmd_vy = vy;
    item.cmd_wz = wz;
    item.tick_dt = 16'($urandom);
    offer_item(item);
  endtask

  task automatic send_tick(input logic [15:0] dt);
    in_item_t item;
    item.op = OP_TICK;
    item.cmd_vx = 16'($urandom);
    item.cmd_vy = 16'($urandom);
    item.cmd_wz = 16'($urandom);
    item.tick_dt = dt;
    offer_item(item);
  endtask

  // called at a falling edge, leaves valid high for the caller to drop
  task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.load_reg(idx, data);
    @(negedge clk_i);
  endtask

  // speeds: fully random, near the clamp range, the 16-bit extremes or zero
  function automatic logic [15:0] pick_speed();
    int r;
    r = $urandom_range(99);
    if (r < 35) return 16'($urandom);
    if (r < 75) return 16'(int'($urandom_range(0, 1200)) - 600);
    if (r < 83) return 16'h7FFF;
    if (r < 91) return 16'h8000;
    return 16'h0000;
  endfunction

  // tick lengths: zero, the cap, above the cap and everything between
  function automatic logic [15:0] pick_dt();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'(DT_CAP);
    if (r < 30) return 16'hFFFF;
    if (r < 65) return 16'($urandom_range(1, DT_CAP));
    if (r < 80) return 16'($urandom_range(DT_CAP + 1, 65535));
    return 16'($urandom);
  endfunction

  // mostly a command followed by a few ticks; the rest lone ticks or command bursts
  task automatic run_random(input int count);
    int left;
    int r;
    int n;
    left = count;
    while (left > 0) begin
      r = $urandom_range(99);
      if (r < 80) begin
        send_cmd(pick_speed(), pick_speed(), pick_speed());
        n = $urandom_range(1, 10);
        repeat (n) send_tick(pick_dt());
        left -= n + 1;
      end else if (r < 90) begin
        n = $urandom_range(1, 5);
        repeat (n) send_tick(pick_dt());
        left -= n;
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) send_cmd(pick_speed(), pick_speed(), pick_speed());
        left -= n;
      end
    end
  endtask

  // wait for every pending result, then let a trailing command finish
  task automatic settle();
    in_valid_i = 1'b0;
    while (sb.pending_count() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // one register setting per call; unused upper data bits carry noise
  task automatic apply_settings(input int pick);
    logic [14:0] lin;
    logic [14:0] ang;
    logic [19:0] tmo;
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] sz;
    logic [15:0] hdg;
    logic [31:0] noise;
    sx = $urandom;
    sy = $urandom;
    sz = $urandom;
    hdg = 16'($urandom);
    case (pick)
      0: begin
        // widest clamps, never expiring, pose right at the wrap points
        lin = 15'h7FFF;
        ang = 15'h7FFF;
        tmo = '0;
        sx = 32'h7FFF_FFF0;
        sy = 32'h8000_0000;
        hdg = 16'hFFFF;
      end
      1: begin
        // everything clamped to zero, shortest nonzero lifetime
        lin = '0;
        ang = '0;
        tmo = 20'd1;
        sx = 32'h8000_0000;
        sy = 32'h7FFF_FFFF;
        hdg = '0;
      end
      2: begin
        lin = 15'($urandom);
        ang = 15'($urandom);
        tmo = 20'hFFFFF;
      end
      3: begin
        lin = 15'($urandom_range(0, 2000));
        ang = 15'($urandom_range(0, 3000));
        tmo = 20'($urandom_range(1, 40000));
      end
      4: begin
        lin = 15'($urandom);
        ang = 15'($urandom_range(0, 1000));
        tmo = 20'($urandom);
      end
      default: begin
        lin = 15'd256;
        ang = 15'd384;
        tmo = 20'd32768;
      end
    endcase
    noise = $urandom;
    write_reg(REG_MAX_LIN, {noise[31:15], lin});
    noise = $urandom;
    write_reg(REG_MAX_ANG, {noise[31:15], ang});
    noise = $urandom;
    write_reg(REG_TIMEOUT, {noise[31:20], tmo});
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_START_Z, sz);
    noise = $urandom;
    write_reg(REG_START_HDG, {noise[31:16], hdg});
    // out-of-range index must leave everything alone
    write_reg(REG_UNUSED, $urandom);
    cfg_valid_i = 1'b0;
  endtask

  initial begin : stimulus
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_MAX_LIN;
    cfg_data_i = '0;
    hold_off_toggle = 1'b0;
    src_idle_pct = 38;
    sink_idle_pct = 68;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed items at the reset register values
    send_tick(16'd0);                          // no command seen yet
    send_tick(16'hFFFF);                       // dt above the cap, still idle
    send_cmd(16'h7FFF, 16'h8000, 16'h8000);    // all three clamp
    send_tick(16'd0);                          // fresh command, zero step
    repeat (4) send_tick(16'(DT_CAP));         // age 26216
    send_tick(16'd6552);                       // age lands exactly on the timeout
    send_tick(16'd1);                          // one past it, command expired
    send_cmd(16'h8000, 16'h7FFF, 16'h7FFF);
    send_tick(16'hFFFF);
    send_cmd(16'h0000, 16'h0000, 16'h0000);    // active but standing still
    send_tick(16'd100);
    send_cmd(16'd255, 16'hFEFF, 16'd383);      // just inside, just outside, just inside
    send_cmd(16'd256, 16'hFF00, 16'hFE80);     // exactly on the limits, back to back
    send_tick(16'(DT_CAP));
    send_tick(16'(DT_CAP + 1));
    send_tick(16'd1);
    send_tick(16'd3000);
    send_cmd(16'hFFFF, 16'h0001, 16'hFFFF);
    send_tick(16'hFFFF);
    send_tick(16'h8000);
    send_tick(16'(DT_CAP - 1));
    settle();

    // sender idles 38 in 100, receiver 68 in 100
    apply_settings(0);
    hold_off_toggle = ~hold_off_toggle;        // block fills and stalls its input
    run_random(220);
    settle();
    apply_settings(1);
    run_random(130);
    settle();

    // the other way round
    src_idle_pct = 68;
    sink_idle_pct = 38;
    apply_settings(2);
    // long coast on one command: expires, then the age saturates
    send_cmd(pick_speed(), pick_speed(), pick_speed());
    repeat (COAST_TICKS) send_tick(16'($urandom_range(DT_CAP, 65535)));
    run_random(130);
    settle();
    apply_settings(3);
    run_random(180);
    settle();

    // no idling on either side
    src_idle_pct = 0;
    sink_idle_pct = 0;
    apply_settings(4);
    run_random(180);
    settle();
    apply_settings(5);
    hold_off_toggle = ~hold_off_toggle;
    run_random(130);
    settle();

    if (sb.mismatch_count == 0 && sb.pending_count() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ppi_pkg.sv
hw/rtl/planar_pose_integrator_top.sv
tb/planar_pose_integrator_top_test.sv
